FILE: hdl/stsc_pkg.sv
package stsc_pkg;

    localparam int KEY_W   = 6;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;
    localparam int TOTAL_W = 6;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_DELETE = 2'd1;
    localparam t_action ACT_SEARCH = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_MISS = 2'd2;

    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic is_ins;
        t_key key;
    } t_cell_cmd;

endpackage

FILE: hdl/stsc_if.sv
interface stsc_req_if import stsc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_action action;
    t_key    card_key;

    modport source (output valid, action, card_key, input ready);
    modport sink (input valid, action, card_key, output ready);
endinterface

interface stsc_rsp_if import stsc_pkg::*; ();
    logic                found;
    logic                valid;
    logic                ready;
    t_status             status;
    logic [POS_W-1:0]    position;
    logic [TOTAL_W-1:0]  entry_total;

    modport source (output valid, found, status, position, entry_total, input ready);
    modport sink (input valid, found, status, position, entry_total, output ready);
endinterface

FILE: hdl/sorted_table_insert_delete_search_core.sv
// sorted key table: insert, delete and search on an ascending list of keys
//
// i_req carries one beat per operation (action, card_key); o_rsp returns one
// beat per operation (found, status, position, entry_total).
// every stored key sits in its own cell of a chain; each cell compares its key
// with the request; on insert or delete each cell at or past the insert or
// delete point takes the new key or a neighbour's key when the request is taken
// the result is registered: it appears in the output register in the cycle after
// the request beat is accepted
// throughput: one operation per cycle unless the receiver stalls, set by the
// single chain compare-and-shift step and the one-hot position encode behind it
// reset empties the table (count to zero) and drops any pending result; cell
// contents are left as they are and are only read below the count
// a stalled receiver holds the result; i_req.ready then stays low until the
// pending result beat is taken, so no operation is lost or repeated
module sorted_table_insert_delete_search_core import stsc_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stsc_req_if.sink   i_req,
    stsc_rsp_if.source o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_oval;
    logic               r_found;
    logic               n_found;
    t_status            r_status;
    t_status            n_status;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [TOTAL_W-1:0] r_total;

    logic               acc;
    logic               full;
    logic               hit;
    logic [IW-1:0]      pos_bin;
    t_cell_cmd          cmd;

    t_key               cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_mark;

    assign i_req.ready = !r_oval || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(CAPACITY));
    assign hit         = |cell_eq;

    assign cmd.key    = i_req.card_key;
    assign cmd.is_ins = (i_req.action == ACT_INSERT);
    assign cmd.ins_en = acc && (i_req.action == ACT_INSERT) && !full;
    assign cmd.del_en = acc && (i_req.action == ACT_DELETE) && hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic left_lt;
            logic left_eq;
            t_key left_key;
            t_key right_key;
            if (g == 0) begin : g_first
                assign left_lt  = 1'b1;
                assign left_eq  = 1'b0;
                assign left_key = '0;
            end else begin : g_mid
                assign left_lt  = cell_lt[g-1];
                assign left_eq  = cell_eq[g-1];
                assign left_key = cell_key[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_key = cell_key[g];
            end else begin : g_inner
                assign right_key = cell_key[g+1];
            end
            stsc_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (cmd),
                .i_valid     (r_count > CW'(g)),
                .i_left_lt   (left_lt),
                .i_left_eq   (left_eq),
                .i_left_key  (left_key),
                .i_right_key (right_key),
                .o_key       (cell_key[g]),
                .o_lt        (cell_lt[g]),
                .o_eq        (cell_eq[g]),
                .o_mark      (cell_mark[g])
            );
        end
    endgenerate

    always_comb begin
        pos_bin = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_mark[i]) begin
                pos_bin = pos_bin | IW'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_found  = 1'b0;
        n_status = ST_OK;
        n_pos    = '0;
        case (i_req.action)
            ACT_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos   = POS_W'(pos_bin);
                    n_count = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(pos_bin);
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_MISS;
                end
            end
            ACT_SEARCH: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(pos_bin);
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
                r_oval  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_oval  <= 1'b0;
            end
        end
        if (acc) begin
            r_found  <= n_found;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_total  <= TOTAL_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_oval;
    assign o_rsp.found       = r_found;
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = r_pos;
    assign o_rsp.entry_total = r_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_en |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the table");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del_en |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink the table");

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cmd.is_ins |-> $onehot0(cell_mark))
        else $error("more than one first match in the table");

    a_total_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_total == TOTAL_W'(r_count))
        else $error("reported total differs from the count");

endmodule

FILE: hdl/stsc_cell.sv
module stsc_cell import stsc_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_valid,
    input  logic      i_left_lt,
    input  logic      i_left_eq,
    input  t_key      i_left_key,
    input  t_key      i_right_key,
    output t_key      o_key,
    output logic      o_lt,
    output logic      o_eq,
    output logic      o_mark
);

    t_key r_key;
    t_key n_key;
    logic lt;
    logic eq;

    assign lt     = i_valid && (r_key < i_cmd.key);
    assign eq     = i_valid && (r_key == i_cmd.key);
    assign o_lt   = lt;
    assign o_eq   = eq;
    assign o_key  = r_key;
    // boundary of the run for insert, first copy of the key otherwise
    assign o_mark = i_cmd.is_ins ? (!lt && i_left_lt) : (eq && !i_left_eq);

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins_en && !lt) begin
            n_key = i_left_lt ? i_cmd.key : i_left_key;
        end else if (i_cmd.del_en && i_valid && !lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
